FILE: hw/rtl/brfd_pkg.sv
// Shared types and constants for the byte-run frame decoder.
package brfd_pkg;

   localparam logic [7:0]  LITERAL_FLAG     = 8'h80;
   localparam logic [15:0] WIDTH_RESET      = 16'd320;
   localparam logic [15:0] HEIGHT_RESET     = 16'd200;
   localparam int          CSR_ADDR_WIDTH   = 3;
   localparam int          CSR_DATA_WIDTH   = 32;
   localparam logic        REG_FRAME_WIDTH  = 1'b0;
   localparam logic        REG_FRAME_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      PH_COUNT,
      PH_TYPE,
      PH_VALUE,
      PH_LITERAL
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] column;
      logic [15:0] line;
      logic [7:0]  packets_left;
      logic [6:0]  literal_left;
      logic [6:0]  run_length;
      logic        finished;
   } state_type;

   typedef struct packed {
      logic [15:0] span_x;
      logic [15:0] span_y;
      logic [7:0]  pixel_value;
      logic [6:0]  span_length;
      logic        overrun;
      logic        frame_done;
   } result_type;

endpackage

FILE: hw/rtl/brfd_step.sv
// Combinational decode of one chunk byte: next decoder state and the span it writes.
module brfd_step (
   input  brfd_pkg::state_type  cur_state,
   input  logic [7:0]           data_byte,
   input  logic                 chunk_start,
   input  logic [15:0]          frame_width,
   input  logic [15:0]          frame_height,
   output brfd_pkg::state_type  nxt_state,
   output brfd_pkg::result_type result,
   output logic                 result_valid
);
   import brfd_pkg::*;

   state_type   st;
   logic        span;
   logic        pkt_done;
   logic        line_done;
   logic        done;
   logic        ovr;
   logic [6:0]  req;
   logic [6:0]  len;
   logic [7:0]  val;
   logic [15:0] avail;
   logic [15:0] x;
   logic [15:0] y;
   logic [7:0]  pkt_left;

   always_comb begin
      st        = cur_state;
      span      = 1'b0;
      pkt_done  = 1'b0;
      line_done = 1'b0;
      done      = 1'b0;
      ovr       = 1'b0;
      req       = '0;
      len       = '0;
      val       = '0;
      avail     = '0;
      pkt_left  = '0;

      // A chunk start wipes the decoder before the byte is taken as a packet count.
      if (chunk_start) begin
         st = '0;
      end
      x = st.column;
      y = st.line;

      unique case (st.phase)
         PH_COUNT: begin
            st.packets_left = data_byte;
            if (data_byte == 8'd0) begin
               line_done = 1'b1;
            end else begin
               st.phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            if ((data_byte & LITERAL_FLAG) != 8'd0) begin
               st.literal_left = ~data_byte[6:0];
               st.phase        = PH_LITERAL;
            end else begin
               st.run_length = data_byte[6:0];
               st.phase      = PH_VALUE;
            end
         end
         PH_VALUE: begin
            span     = 1'b1;
            req      = st.run_length;
            val      = data_byte;
            pkt_done = 1'b1;
         end
         PH_LITERAL: begin
            span = 1'b1;
            req  = 7'd1;
            val  = data_byte;
            if (st.literal_left == 7'd0) begin
               pkt_done = 1'b1;
            end else begin
               st.literal_left = st.literal_left - 7'd1;
            end
         end
         default: begin
            st.phase = PH_COUNT;
         end
      endcase

      if (span) begin
         avail = (st.column < frame_width) ? (frame_width - st.column) : 16'd0;
         ovr   = {9'd0, req} > avail;
         len   = ovr ? avail[6:0] : req;
         st.column = st.column + {9'd0, len};
      end

      if (pkt_done) begin
         pkt_left        = st.packets_left - 8'd1;
         st.packets_left = pkt_left;
         if (pkt_left == 8'd0) begin
            line_done = 1'b1;
         end else begin
            st.phase = PH_TYPE;
         end
      end

      if (line_done) begin
         st.phase = PH_COUNT;
         if (({1'b0, st.line} + 17'd1) >= {1'b0, frame_height}) begin
            st.finished = 1'b1;
            done        = 1'b1;
         end else begin
            st.column = '0;
            st.line   = st.line + 16'd1;
         end
      end

      result.span_x      = x;
      result.span_y      = y;
      result.pixel_value = (len == 7'd0) ? 8'd0 : val;
      result.span_length = len;
      result.overrun     = ovr;
      result.frame_done  = done;

      // Once the frame is complete, bytes leave the decoder untouched until a chunk start.
      if (cur_state.finished && !chunk_start) begin
         nxt_state    = cur_state;
         result_valid = 1'b0;
      end else begin
         nxt_state    = st;
         result_valid = (len != 7'd0) || done;
      end
   end

endmodule

FILE: hw/rtl/byte_run_frame_decoder_core.sv
// Top level of the byte-run frame decoder: input stage, decode step, result stage, registers.
// Path: a beat accepted into the input register is decoded and loaded into the result register,
// which drives the result port; a stalled result register can hold the beat in the input stage.
// Throughput: one byte per cycle; the decode state update is a single registered pass.
// Only a stalled result register holds back the input, through the input stage.
// Reset (synchronous, active high) empties both stages, clears the decode state and
// returns frame_width to 320 and frame_height to 200.
module byte_run_frame_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] chunk_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] span_x, [31:16] span_y, [39:32] pixel_value,
                                    // [46:40] span_length, [47] zero
   output logic        rsp_tuser,   // [0] overrun
   output logic        rsp_tlast,   // frame_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [brfd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [brfd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [brfd_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic        csr_pready
);
   import brfd_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;
   state_type   state_ff;
   state_type   state_in;
   result_type  result_in;
   result_type  result_ff;
   logic        result_valid;
   logic        out_valid_ff;
   logic [15:0] width_ff;
   logic [15:0] height_ff;
   logic        fire;
   logic        load;
   logic        csr_write;

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign load       = fire && result_valid;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   brfd_step u_step (
      .cur_state    (state_ff),
      .data_byte    (in_byte_ff),
      .chunk_start  (in_start_ff),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .nxt_state    (state_in),
      .result       (result_in),
      .result_valid (result_valid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff.span_length, result_ff.pixel_value,
                        result_ff.span_y, result_ff.span_x};
   assign rsp_tuser  = result_ff.overrun;
   assign rsp_tlast  = result_ff.frame_done;

   // Register file: the low address bits below the word offset are not decoded.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_FRAME_WIDTH:  width_ff  <= csr_pwdata[15:0];
            REG_FRAME_HEIGHT: height_ff <= csr_pwdata[15:0];
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = {16'd0, width_ff};
         REG_FRAME_HEIGHT: csr_prdata = {16'd0, height_ff};
         default:          csr_prdata = '0;
      endcase
   end

   a_zero_len_is_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[46:40] == 7'd0)) |-> (rsp_tlast && (rsp_tdata[39:32] == 8'd0)))
      else $error("zero-length span without frame done marker");

   a_done_sets_finished: assert property (@(posedge clock) disable iff (reset)
      (load && result_in.frame_done) |=> state_ff.finished)
      else $error("frame done result did not mark the frame finished");

   a_finished_is_silent: assert property (@(posedge clock) disable iff (reset)
      (fire && state_ff.finished && !in_start_ff) |-> !load)
      else $error("result produced after the frame was finished");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(result_ff)))
      else $error("pending result changed while stalled");

endmodule

FILE: verif/byte_run_frame_decoder_core_tb.sv
// Self-checking testbench for the byte-run frame decoder core, with a span predictor and scoreboard.
module byte_run_frame_decoder_core_tb;
   import brfd_pkg::*;

   localparam int PHASE_BYTES   = 165;
   localparam int PHASE_COUNT   = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 500000;

   // Tracks the decoder state and keeps the spans still owed by the block, oldest first.
   class frame_decode_scoreboard;
      logic [15:0] frame_width;
      logic [15:0] frame_height;
      phase_type   phase;
      logic [15:0] column;
      logic [15:0] line;
      logic [7:0]  packets_left;
      logic [6:0]  literal_left;
      logic [6:0]  run_length;
      bit          finished;
      result_type  pending_spans[$];
      int          mismatches;

      function new();
         frame_width  = WIDTH_RESET;
         frame_height = HEIGHT_RESET;
         mismatches   = 0;
         clear_state();
      endfunction

      function void clear_state();
         phase        = PH_COUNT;
         column       = '0;
         line         = '0;
         packets_left = '0;
         literal_left = '0;
         run_length   = '0;
         finished     = 1'b0;
      endfunction

      function void set_register(logic index, logic [15:0] value);
         if (index == REG_FRAME_WIDTH) begin
            frame_width = value;
         end else begin
            frame_height = value;
         end
      endfunction

      function void note_byte(logic [7:0] b, logic start);
         logic [15:0] x;
         logic [15:0] y;
         logic [7:0]  val;
         int unsigned req;
         int unsigned avail;
         int unsigned len;
         bit          span;
         bit          ovr;
         bit          pkt_done;
         bit          line_done;
         bit          done;
         result_type  r;
         if (start) begin
            clear_state();
         end else if (finished) begin
            return;
         end
         x = column;
         y = line;
         val = '0;
         req = 0;
         len = 0;
         span = 0;
         ovr = 0;
         pkt_done = 0;
         line_done = 0;
         done = 0;
         case (phase)
            PH_COUNT: begin
               packets_left = b;
               if (b == 8'd0) begin
                  line_done = 1;
               end else begin
                  phase = PH_TYPE;
               end
            end
            PH_TYPE: begin
               if ((b & LITERAL_FLAG) != 8'd0) begin
                  // A literal of (256 - type) bytes; the counter holds the literal bytes after the first one.
                  literal_left = ~b[6:0];
                  phase = PH_LITERAL;
               end else begin
                  run_length = b[6:0];
                  phase = PH_VALUE;
               end
            end
            PH_VALUE: begin
               span = 1;
               req = run_length;
               val = b;
               pkt_done = 1;
            end
            default: begin
               span = 1;
               req = 1;
               val = b;
               if (literal_left == 7'd0) begin
                  pkt_done = 1;
               end else begin
                  literal_left = literal_left - 7'd1;
               end
            end
         endcase
         if (span) begin
            avail = (column < frame_width) ? (int'(frame_width) - int'(column)) : 0;
            len = (req < avail) ? req : avail;
            ovr = req > avail;
            column = column + 16'(len);
         end
         if (pkt_done) begin
            packets_left = packets_left - 8'd1;
            if (packets_left == 8'd0) begin
               line_done = 1;
            end else begin
               phase = PH_TYPE;
            end
         end
         if (line_done) begin
            phase = PH_COUNT;
            if (({1'b0, line} + 17'd1) >= {1'b0, frame_height}) begin
               finished = 1'b1;
               done = 1;
            end else begin
               column = '0;
               line = line + 16'd1;
            end
         end
         if (len == 0 && !done) begin
            return;
         end
         r.span_x      = x;
         r.span_y      = y;
         r.pixel_value = (len == 0) ? 8'd0 : val;
         r.span_length = 7'(len);
         r.overrun     = ovr;
         r.frame_done  = done;
         pending_spans.push_back(r);
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_span(logic [47:0] data, logic user, logic last);
         result_type want;
         if (pending_spans.size() == 0) begin
            $display("%0t: unexpected span, expected none, actual tdata %h overrun %b done %b",
                     $time, data, user, last);
            mismatches++;
            return;
         end
         want = pending_spans.pop_front();
         compare_field("span_x", want.span_x, data[15:0]);
         compare_field("span_y", want.span_y, data[31:16]);
         compare_field("pixel_value", want.pixel_value, data[39:32]);
         compare_field("span_length", want.span_length, data[46:40]);
         compare_field("tdata pad", 0, data[47]);
         compare_field("overrun", want.overrun, user);
         compare_field("frame_done", want.frame_done, last);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] data_byte
   logic        req_tuser = 1'b0; // [0] chunk_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [15:0] span_x, [31:16] span_y, [39:32] pixel_value,
                                  // [46:40] span_length, [47] zero
   logic        rsp_tuser;        // [0] overrun
   logic        rsp_tlast;        // frame_done
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic        csr_pready;

   frame_decode_scoreboard sb;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_req_cnt = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          cycle_count = 0;
   logic [7:0]  frame_bytes[$];

   byte_run_frame_decoder_core dut (.*);

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side: checks each accepted beat and decides the next ready, including the long hold.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_span(rsp_tdata, rsp_tuser, rsp_tlast);
      end
      if (hold_seen != hold_req_cnt) begin
         hold_seen = hold_req_cnt;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic start);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(value, start);
   endtask

   task automatic wait_for_spans();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending_spans.size() != 0);
   endtask

   task automatic csr_write(input logic index, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'({index, 2'b00});
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.set_register(index, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check_read(input logic index);
      logic [15:0] want;
      want = (index == REG_FRAME_WIDTH) ? sb.frame_width : sb.frame_height;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_WIDTH'({index, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[15:0] !== want) begin
         $display("%0t: register %0d read mismatch, expected %0h, actual %0h",
                  $time, index, want, csr_prdata[15:0]);
         sb.mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Builds one well-formed chunk body for the current frame size; tall frames get a few lines.
   task automatic build_frame();
      int unsigned lines;
      int unsigned packets;
      int unsigned n;
      frame_bytes.delete();
      if (sb.frame_height == 0) begin
         lines = 1;
      end else if (sb.frame_height > 4) begin
         lines = $urandom_range(3, 1);
      end else begin
         lines = sb.frame_height;
      end
      repeat (lines) begin
         packets = $urandom_range(4, 0);
         frame_bytes.push_back(8'(packets));
         repeat (packets) begin
            if ($urandom_range(1) == 1) begin
               n = ($urandom_range(39) == 0) ? 128 : $urandom_range(6, 1);
               frame_bytes.push_back(8'(256 - n));
               repeat (n) frame_bytes.push_back(8'($urandom));
            end else begin
               n = ($urandom_range(9) == 0) ? $urandom_range(127, 0) : $urandom_range(12, 0);
               frame_bytes.push_back(8'(n));
               frame_bytes.push_back(8'($urandom));
            end
         end
      end
   endtask

   initial begin
      // Each entry is {chunk_start, data_byte}.
      logic [8:0] directed_beats[] = '{
         9'h103, 9'h002, 9'h0FF, 9'h0FE, 9'h000, 9'h07F, 9'h005, 9'h011, 9'h000, 9'h055,
         9'h101, 9'h000, 9'h0AB, 9'h001, 9'h07F, 9'h080,
         9'h1FF, 9'h0FF, 9'h000, 9'h080, 9'h001, 9'h002, 9'h100, 9'h000};
      int phase_bytes;
      int pick;
      int cut;
      bit paused;
      logic [15:0] new_width;
      logic [15:0] new_height;

      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check_read(REG_FRAME_WIDTH);
      csr_check_read(REG_FRAME_HEIGHT);

      // Directed: a small frame with a run, a literal, a clipped run and a bare done marker,
      // then a zero run, a full-width overrun ending the frame, and restarts mid-frame.
      csr_write(REG_FRAME_WIDTH, 16'd4);
      csr_write(REG_FRAME_HEIGHT, 16'd2);
      foreach (directed_beats[i]) begin
         send_byte(directed_beats[i][7:0], directed_beats[i][8]);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_for_spans();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (p)
            0: begin new_width = 16'd16;    new_height = 16'd3;     end
            1: begin new_width = 16'd1;     new_height = 16'd1;     end
            2: begin new_width = 16'hFFFF;  new_height = 16'hFFFF;  end
            3: begin new_width = 16'd0;     new_height = 16'd2;     end
            4: begin new_width = 16'd7;     new_height = 16'd0;     end
            6: begin new_width = WIDTH_RESET; new_height = HEIGHT_RESET; end
            default: begin
               new_width  = 16'($urandom_range(40, 1));
               new_height = 16'($urandom_range(4, 1));
            end
         endcase
         csr_write(REG_FRAME_WIDTH, new_width);
         csr_write(REG_FRAME_HEIGHT, new_height);
         csr_check_read(REG_FRAME_WIDTH);
         csr_check_read(REG_FRAME_HEIGHT);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 73; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 73; end
            default: begin send_idle_pct = 25; stall_pct <= 25; end
         endcase
         // The first phase opens with the receiver held off while beats keep coming.
         if (p == 0) begin
            hold_req_cnt <= hold_req_cnt + 1;
         end
         phase_bytes = 0;
         paused = 0;
         while (phase_bytes < PHASE_BYTES) begin
            pick = $urandom_range(99);
            build_frame();
            if (pick < 70) begin
               foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == 0);
               phase_bytes += frame_bytes.size();
               repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0);
            end else if (pick < 85) begin
               cut = $urandom_range(frame_bytes.size(), 1);
               for (int i = 0; i < cut; i++) send_byte(frame_bytes[i], i == 0);
               phase_bytes += cut;
            end else begin
               cut = $urandom_range(12, 1);
               repeat (cut) send_byte(8'($urandom), $urandom_range(7) == 0);
               phase_bytes += cut;
            end
            if (!paused && phase_bytes >= PHASE_BYTES / 2) begin
               wait_for_spans();
               paused = 1;
            end
         end
      end

      wait_for_spans();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_spans.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: byte_run_frame_decoder_core.f
hw/rtl/brfd_pkg.sv
hw/rtl/brfd_step.sv
hw/rtl/byte_run_frame_decoder_core.sv
verif/byte_run_frame_decoder_core_tb.sv
